@@ hdl/butterworth_bandpass_cascade_top_defines.svh @@
// Assertion macros for the band-pass cascade.
// Used by the top level only; no other dependencies.
`ifndef BUTTERWORTH_BANDPASS_CASCADE_TOP_DEFINES_SVH
`define BUTTERWORTH_BANDPASS_CASCADE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BBC_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("bbc check failed");
`define BBC_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("bbc check failed");
`else
`define BBC_ASSERT_IMPL(label, clk, rst, prop)
`define BBC_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ hdl/bbc_pkg.sv @@
// Package for the band-pass cascade: widths, constants and section codes.
// Used by all modules of the block; no dependencies.
package bbc_pkg;
   localparam int SectionsDefault = 2;
   localparam int CoefFracDefault = 20;
   localparam int DelayFrac = 8;
   localparam int WordW = 40;
   localparam int CoefW = 24;
   localparam int SampleW = 16;
   localparam int ProdW = WordW + CoefW;
   localparam int DigitW = 4;
   localparam logic [2:0] CoefGain = 3'd0;
   localparam logic [2:0] CoefLast = 3'd4;
   localparam logic [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
   localparam logic [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};

   // Saturates a wider signed value to the 40-bit word range.
   function automatic logic [WordW-1:0] sat40(input logic signed [ProdW-1:0] v);
      logic signed [ProdW-1:0] hi;
      logic signed [ProdW-1:0] lo;
      hi = {{(ProdW-WordW){1'b0}}, WordMax};
      lo = {{(ProdW-WordW){1'b1}}, WordMin};
      if (v > hi) sat40 = WordMax;
      else if (v < lo) sat40 = WordMin;
      else sat40 = v[WordW-1:0];
   endfunction
endpackage

@@ hdl/bbc_digit_mul.sv @@
// Digit-serial signed multiplier: coefficient times 40-bit word, 4 bits a cycle.
// Depends on bbc_pkg.
module bbc_digit_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [bbc_pkg::CoefW-1:0]   coef,
   input  logic signed [bbc_pkg::WordW-1:0]   word,
   output logic                               done,
   output logic signed [bbc_pkg::ProdW-1:0]   product
);
   localparam int Steps = bbc_pkg::WordW / bbc_pkg::DigitW;
   localparam int CntW = $clog2(Steps + 1);

   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic signed [bbc_pkg::CoefW-1:0] coef_ff, coef_in;
   logic [bbc_pkg::WordW-1:0] word_ff, word_in;
   logic signed [bbc_pkg::ProdW-1:0] acc_ff, acc_in;
   logic signed [bbc_pkg::CoefW+bbc_pkg::DigitW:0] part;
   logic signed [bbc_pkg::DigitW:0] digit;
   logic top_digit;

   // The top digit of the word is signed; the others are unsigned.
   assign top_digit = (cnt_ff == '0);
   assign digit = top_digit ? {word_ff[bbc_pkg::WordW-1], word_ff[bbc_pkg::WordW-1 -: bbc_pkg::DigitW]}
                            : {1'b0, word_ff[bbc_pkg::WordW-1 -: bbc_pkg::DigitW]};
   assign part = coef_ff * digit;

   // Shift-and-add from the most significant digit down, then one done cycle.
   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      coef_in = coef_ff;
      word_in = word_ff;
      acc_in = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         coef_in = coef;
         word_in = word;
         acc_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff == CntW'(Steps)) busy_in = 1'b0;
         else begin
            acc_in = (acc_ff <<< bbc_pkg::DigitW) + bbc_pkg::ProdW'(part);
            word_in = word_ff << bbc_pkg::DigitW;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end
   // Note: MSB-first digit order means first step uses the signed top digit.

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      coef_ff <= coef_in;
      word_ff <= word_in;
      acc_ff <= acc_in;
   end

   assign done = busy_ff && (cnt_ff == CntW'(Steps));
   assign product = acc_ff;
endmodule

@@ hdl/butterworth_bandpass_cascade_top.sv @@
// Top level of the band-pass cascade: sequencer, coefficient and delay storage.
// Depends on bbc_pkg, bbc_digit_mul and the assertion macro header.
//
// Usage: the req_ channel carries one transaction per command. cmd 1 writes one
// coefficient (gain or feedback 1..4 of a section) and gives no result; it is
// accepted whenever the sequencer is idle. cmd 0 filters one sample
// through all SECTIONS sections in turn and gives one rsp_ transaction with the
// rounded, saturated output and a clipped flag. Each section runs five products
// on one shared multiplier that takes a 40-bit word four bits a cycle. A
// combine step follows the four feedback products, and the gain product comes
// last; the sequencer waits for the multiplier to finish each product.
// One sample is worked at a time; req_stall is high while it is in work. The
// result sits in an output register and is held while rsp_stall is high; a
// finished sample waits for that register to empty before the sequencer idles.
// Reset clears all delay words and coefficients to zero and empties the
// output register.
`include "butterworth_bandpass_cascade_top_defines.svh"
module butterworth_bandpass_cascade_top #(
   parameter int SECTIONS = bbc_pkg::SectionsDefault,
   parameter int COEF_FRAC_BITS = bbc_pkg::CoefFracDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [bbc_pkg::SampleW-1:0]    req_sample_in,
   input  logic [2:0]                            req_section_sel,
   input  logic [2:0]                            req_coef_sel,
   input  logic signed [bbc_pkg::CoefW-1:0]      req_coef_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bbc_pkg::SampleW-1:0]    rsp_sample_out,
   output logic                                  rsp_clipped
);
   localparam int WW = bbc_pkg::WordW;
   localparam int PW = bbc_pkg::ProdW;
   localparam int SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_WAIT, S_COMB, S_GAIN, S_GWAIT, S_OUT
   } state_type;

   state_type state_ff;
   logic [SecW-1:0] sec_ff;
   logic [2:0] tap_ff;
   logic signed [WW-1:0] u_ff;
   logic signed [PW-1:0] acc_ff;
   logic signed [WW-1:0] w0_ff;
   logic signed [WW-1:0] dly_ff [SECTIONS][4];
   logic signed [bbc_pkg::CoefW-1:0] coef_ff [SECTIONS][5];
   logic rsp_valid_ff;
   logic signed [bbc_pkg::SampleW-1:0] out_ff;
   logic clip_ff;

   logic mul_start;
   logic mul_done;
   logic signed [bbc_pkg::CoefW-1:0] mul_coef;
   logic signed [WW-1:0] mul_word;
   logic signed [PW-1:0] mul_prod;
   logic signed [PW-1:0] rounded;
   logic req_take;
   logic signed [WW+2:0] comb;
   logic signed [WW-bbc_pkg::DelayFrac:0] fin;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;

   // Operand select for the shared multiplier.
   always_comb begin
      mul_coef = coef_ff[sec_ff][tap_ff + 3'd1];
      mul_word = (state_ff == S_GAIN) ? bbc_pkg::sat40(PW'(comb))
                                      : dly_ff[sec_ff][tap_ff[1:0]];
   end

   bbc_digit_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .coef((state_ff == S_GAIN || state_ff == S_GWAIT) ? coef_ff[sec_ff][0] : mul_coef),
      .word(mul_word), .done(mul_done), .product(mul_prod)
   );
   assign mul_start = (state_ff == S_MUL) || (state_ff == S_GAIN);

   // Round the product to the delay format.
   assign rounded = (mul_prod + (PW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
   assign comb = (WW+3)'(w0_ff) - ((WW+3)'(dly_ff[sec_ff][1]) <<< 1) + (WW+3)'(dly_ff[sec_ff][3]);
   assign fin = (WW-bbc_pkg::DelayFrac+1)'(((WW+1)'(u_ff)
                + (WW+1)'(1 << (bbc_pkg::DelayFrac-1))) >>> bbc_pkg::DelayFrac);

   // Sequencer, storage and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SECTIONS; s++) begin
            for (int k = 0; k < 4; k++) dly_ff[s][k] <= '0;
            for (int k = 0; k < 5; k++) coef_ff[s][k] <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  if (req_cmd) begin
                     if (32'(req_section_sel) < SECTIONS && req_coef_sel <= bbc_pkg::CoefLast)
                        coef_ff[req_section_sel[SecW-1:0]][req_coef_sel] <= req_coef_value;
                  end else begin
                     u_ff <= WW'(req_sample_in) <<< bbc_pkg::DelayFrac;
                     sec_ff <= '0;
                     tap_ff <= '0;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               if (tap_ff == 3'd0) acc_ff <= PW'(u_ff);
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (mul_done) begin
                  acc_ff <= acc_ff + rounded;
                  if (tap_ff == 3'd3) state_ff <= S_COMB;
                  else begin
                     tap_ff <= tap_ff + 1'b1;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_COMB: begin
               w0_ff <= bbc_pkg::sat40(acc_ff);
               state_ff <= S_GAIN;
            end
            S_GAIN: begin
               dly_ff[sec_ff][3] <= dly_ff[sec_ff][2];
               dly_ff[sec_ff][2] <= dly_ff[sec_ff][1];
               dly_ff[sec_ff][1] <= dly_ff[sec_ff][0];
               dly_ff[sec_ff][0] <= w0_ff;
               state_ff <= S_GWAIT;
            end
            S_GWAIT: begin
               if (mul_done) begin
                  u_ff <= bbc_pkg::sat40(rounded);
                  if (32'(sec_ff) == SECTIONS - 1) state_ff <= S_OUT;
                  else begin
                     sec_ff <= sec_ff + 1'b1;
                     tap_ff <= '0;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  if (fin > 32767) begin
                     out_ff <= 16'sh7fff; clip_ff <= 1'b1;
                  end else if (fin < -32768) begin
                     out_ff <= 16'sh8000; clip_ff <= 1'b1;
                  end else begin
                     out_ff <= fin[15:0]; clip_ff <= 1'b0;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = out_ff;
   assign rsp_clipped = clip_ff;

   `BBC_ASSERT_IMPL(a_stall_busy, clock, reset, (state_ff != S_IDLE) |-> req_stall)
   `BBC_ASSERT_IMPL(a_hold_rsp, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid)
   `BBC_ASSERT_IMPL(a_sec_range, clock, reset, (state_ff != S_IDLE) |-> (32'(sec_ff) < SECTIONS))
endmodule

@@ test/tb_butterworth_bandpass_cascade_top.sv @@
// Testbench for the band-pass IIR cascade: directed and random samples and coefficient writes.
// Depends on bbc_pkg and butterworth_bandpass_cascade_top; predicts outputs with a scoreboard class.
module tb_butterworth_bandpass_cascade_top;

   localparam int NSec = 2;
   localparam int FracBits = 20;
   localparam logic CmdFilter = 1'b0;
   localparam logic CmdCoef = 1'b1;
   localparam int RandomCount = 900;
   localparam longint CycleLimit = 2000000;

   // Prediction of the cascade, with its own delay line and coefficients.
   class bandpass_scoreboard;
      longint taps[4*NSec];
      longint coefs[5*NSec];
      logic signed [15:0] out_q[$];
      logic clip_q[$];
      int errors;

      function new();
         foreach (taps[i]) taps[i] = 0;
         foreach (coefs[i]) coefs[i] = 0;
         errors = 0;
      endfunction

      function longint sat_word(longint v);
         if (v > 64'sd549755813887) return 64'sd549755813887;
         if (v < -64'sd549755813888) return -64'sd549755813888;
         return v;
      endfunction

      function longint scale_coef(longint c, longint w);
         return (c * w + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      endfunction

      task report(string what, longint want, longint got);
         errors++;
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      endtask

      // Notes an accepted transaction and queues the expected output of a sample.
      function void note_input(logic cmd, logic signed [15:0] smp, logic [2:0] sec,
                               logic [2:0] csel, logic signed [23:0] val);
         longint u, y, w0, comb, r;
         int b;
         if (cmd == CmdCoef) begin
            if (sec < NSec && csel <= bbc_pkg::CoefLast) coefs[sec*5 + csel] = val;
            return;
         end
         u = longint'(smp) * 256;
         y = 0;
         for (int s = 0; s < NSec; s++) begin
            b = s * 4;
            w0 = scale_coef(coefs[s*5+1], taps[b]) + scale_coef(coefs[s*5+2], taps[b+1])
               + scale_coef(coefs[s*5+3], taps[b+2]) + scale_coef(coefs[s*5+4], taps[b+3]) + u;
            w0 = sat_word(w0);
            comb = sat_word(w0 - 2 * taps[b+1] + taps[b+3]);
            y = sat_word(scale_coef(coefs[s*5], comb));
            taps[b+3] = taps[b+2];
            taps[b+2] = taps[b+1];
            taps[b+1] = taps[b];
            taps[b] = w0;
            u = y;
         end
         r = (y + (64'sd1 <<< (bbc_pkg::DelayFrac - 1))) >>> bbc_pkg::DelayFrac;
         if (r > 32767) begin
            out_q.push_back(16'sd32767);
            clip_q.push_back(1'b1);
         end else if (r < -32768) begin
            out_q.push_back(-16'sd32768);
            clip_q.push_back(1'b1);
         end else begin
            out_q.push_back(16'(r));
            clip_q.push_back(1'b0);
         end
      endfunction

      // Compares one output transaction with the oldest expectation.
      task check_output(logic signed [15:0] smp, logic clip);
         logic signed [15:0] exp_s;
         logic exp_c;
         if (out_q.size() == 0) begin
            report("output with nothing expected", 0, smp);
            return;
         end
         exp_s = out_q.pop_front();
         exp_c = clip_q.pop_front();
         if (smp !== exp_s) report("sample_out", exp_s, smp);
         if (clip !== exp_c) report("clipped", exp_c, clip);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = 1'b0;
   logic signed [15:0] req_sample_in = '0;
   logic [2:0] req_section_sel = '0;
   logic [2:0] req_coef_sel = '0;
   logic signed [23:0] req_coef_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic rsp_clipped;

   bandpass_scoreboard board = new();
   bit quiet = 1'b0;
   bit hold_off = 1'b0;
   longint cycles = 0;

   butterworth_bandpass_cascade_top #(.SECTIONS(NSec), .COEF_FRAC_BITS(FracBits)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_sample_in(req_sample_in), .req_section_sel(req_section_sel),
      .req_coef_sel(req_coef_sel), .req_coef_value(req_coef_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out), .rsp_clipped(rsp_clipped)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Output side: sample at the rising edge, check each accepted transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_output(rsp_sample_out, rsp_clipped);
   end

   // Receiver stall: random bursts, one long hold-off, none in the quiet tail.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall <= 1'b0;
            wait (!hold_off);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
      end
   end

   // Offers one transaction and waits for it to be taken; valid stays high
   // into the next transaction unless an idle gap comes first.
   task automatic send(logic cmd, logic signed [15:0] smp, logic [2:0] sec,
                       logic [2:0] csel, logic signed [23:0] val);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_sample_in <= smp;
      req_section_sel <= sec;
      req_coef_sel <= csel;
      req_coef_value <= val;
      do @(posedge clock); while (req_stall);
      board.note_input(cmd, smp, sec, csel, val);
      @(negedge clock);
   endtask

   task automatic write_coef(int sec, int csel, int val);
      send(CmdCoef, 16'(~$urandom), 3'(sec), 3'(csel), 24'(val));
   endtask

   task automatic filter(int smp);
      send(CmdFilter, 16'(smp), 3'($urandom), 3'($urandom), 24'($urandom));
   endtask

   // Loads a stable-ish random section set: modest feedback, gain between minus one and one.
   task automatic load_mild_coefs();
      for (int s = 0; s < NSec; s++) begin
         write_coef(s, bbc_pkg::CoefGain, $urandom_range(0, 1 << 21) - (1 << 20));
         for (int c = 1; c <= 4; c++)
            write_coef(s, c, $urandom_range(0, 1 << 19) - (1 << 18));
      end
   endtask

   task automatic drain();
      while (board.out_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      int k;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: all-zero coefficients give zero output.
      filter(32767);
      filter(-32768);
      // Unity gain, no feedback, then extreme coefficients and samples.
      write_coef(0, bbc_pkg::CoefGain, 1 << 20);
      write_coef(1, bbc_pkg::CoefGain, 1 << 20);
      filter(32767);
      filter(-32768);
      filter(0);
      write_coef(0, bbc_pkg::CoefGain, 8388607);
      write_coef(1, bbc_pkg::CoefGain, -8388608);
      filter(32767);
      filter(-32768);
      write_coef(0, 1, 8388607);
      write_coef(0, 2, -8388608);
      write_coef(1, 3, 8388607);
      write_coef(1, 4, -8388608);
      filter(32767);
      filter(32767);
      filter(-32768);
      // Writes to a missing section or selector are ignored.
      write_coef(7, bbc_pkg::CoefGain, 0);
      write_coef(NSec, 1, 0);
      write_coef(0, 5, 0);
      write_coef(1, 7, 0);
      filter(12345);

      // Random: mostly mild coefficient sets with runs of samples.
      for (int i = 0; i < RandomCount; i++) begin
         if (i == 300) begin
            hold_off = 1'b1;
            repeat (20) filter($urandom_range(0, 65535) - 32768);
            hold_off = 1'b0;
         end
         if (i == RandomCount - 150) quiet = 1'b1;
         k = $urandom_range(0, 99);
         if (k < 3) load_mild_coefs();
         else if (k < 8)
            send(CmdCoef, 16'($urandom), 3'($urandom), 3'($urandom), 24'($urandom));
         else if (k < 12)
            filter($urandom_range(0, 1) ? 32767 : -32768);
         else
            filter($urandom_range(0, 65535) - 32768);
      end
      req_valid <= 1'b0;

      drain();
      repeat (200) @(negedge clock);
      if (board.errors == 0 && board.out_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
